[rtl/cab_pkg.sv]
`timescale 1ns / 1ps

package cab_pkg;

	localparam int unsigned COORD_W   = 16;
	localparam int unsigned PIX_W     = 32;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned IN_DATA_W = 96;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

	// register indexes of the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_TOP    = 3'd1,
		REG_CLIP_RIGHT  = 3'd2,
		REG_CLIP_BOTTOM = 3'd3,
		REG_DRAW_COLOR  = 3'd4,
		REG_DRAW_MODE   = 3'd5
	} cab_reg_idx_t;

	// draw modes
	typedef enum logic {
		MODE_FILL  = 1'b0,
		MODE_IMAGE = 1'b1
	} cab_mode_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] clip_left;
		logic signed [COORD_W-1:0] clip_top;
		logic signed [COORD_W-1:0] clip_right;
		logic signed [COORD_W-1:0] clip_bottom;
		logic [PIX_W-1:0]          draw_color;
		cab_mode_t                 draw_mode;
	} cab_cfg_t;

	// control shared by the three color lanes
	typedef struct packed {
		logic              en_s2;
		logic              en_s3;
		cab_mode_t         mode_s1;
		cab_mode_t         mode_s2;
		logic [CHAN_W-1:0] color_a;
		logic [CHAN_W-1:0] sa_s1;
		logic [CHAN_W-1:0] sa_s2;
	} cab_lane_ctl_t;

	function automatic logic [CHAN_W-1:0] byte_at(input logic [PIX_W-1:0] p,
			input int unsigned idx);
		byte_at = p[idx*CHAN_W +: CHAN_W];
	endfunction

endpackage

[rtl/clip_and_alpha_blend_pixel.sv]
`timescale 1ns / 1ps

// Clip-and-blend pixel unit for an 8-bit ARGB frame buffer. One pixel beat
// enters per clock and its result leaves three register stages later: stage
// one captures the pixel with its clip test and scaled source alpha, stage two
// forms the 8x8 products of each color lane, stage three adds (fill) or applies
// the tint scale and adds (image blit). Sustained rate is one pixel per clock;
// each stage holds only while the stage behind it is full and stalled, so a
// stall on m_tready costs no beats. Pixels outside the clip rectangle, or any
// pixel while the draw color alpha is zero, return write_enable 0 and the
// destination pixel unchanged. Blended pixels keep the destination alpha.
// Configuration writes are taken every cycle and should be issued only while
// no pixel is in flight.
module clip_and_alpha_blend_pixel (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pixel_x[15:0], pixel_y[31:16], dst_pixel[63:32], src_pixel[95:64]
	input  logic [cab_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// write_enable[0], out_pixel[32:1], zero pad[39:33]
	output logic [cab_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cab_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cab_pkg::CFG_DAT_W-1:0]       cfg_data
);

	localparam int unsigned W  = cab_pkg::CHAN_W;
	localparam int unsigned PW = cab_pkg::PIX_W;
	localparam int unsigned CW = cab_pkg::COORD_W;

	cab_pkg::cab_cfg_t      cfg;
	cab_pkg::cab_lane_ctl_t ctl;

	logic signed [CW-1:0] in_x;
	logic signed [CW-1:0] in_y;
	logic [PW-1:0]        in_dst;
	logic [PW-1:0]        in_src;
	logic [W-1:0]         color_a;
	logic                 in_clip;
	logic [2*W-1:0]       sa_prod;

	logic                 v_s1, v_s2, v_s3;
	logic                 adv1, adv2, adv3;

	logic                 we_s1, we_s2, we_s3;
	logic                 full_s1, full_s2, full_s3;
	cab_pkg::cab_mode_t   mode_s1, mode_s2;
	logic [W-1:0]         sa_s1, sa_s2;
	logic [PW-1:0]        dst_s1, dst_s2, dst_s3;
	logic [PW-1:0]        src_s1;
	logic [3*W-1:0]       blend_s3;
	logic [PW-1:0]        out_pixel;

	cab_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// unpack the input beat
	assign in_x   = s_tdata[CW-1:0];
	assign in_y   = s_tdata[2*CW-1:CW];
	assign in_dst = s_tdata[2*CW+PW-1:2*CW];
	assign in_src = s_tdata[2*CW+2*PW-1:2*CW+PW];

	assign color_a = cab_pkg::byte_at(cfg.draw_color, 3);
	assign in_clip = (in_x >= cfg.clip_left) && (in_x < cfg.clip_right)
		&& (in_y >= cfg.clip_top) && (in_y < cfg.clip_bottom);
	assign sa_prod = cab_pkg::byte_at(in_src, 3) * color_a;

	// advance a stage when it is empty or the next one moves
	assign adv3     = !v_s3 || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// stage one: capture pixel, clip test and scaled source alpha
	always_ff @(posedge clk) begin
		if (adv1) begin
			we_s1   <= in_clip && (color_a != '0);
			full_s1 <= (cfg.draw_mode == cab_pkg::MODE_FILL) && (color_a == cab_pkg::CHAN_MAX);
			mode_s1 <= cfg.draw_mode;
			sa_s1   <= sa_prod[2*W-1:W];
			dst_s1  <= in_dst;
			src_s1  <= in_src;
		end
	end

	// stage two: carry flags beside the lane products
	always_ff @(posedge clk) begin
		if (adv2) begin
			we_s2   <= we_s1;
			full_s2 <= full_s1;
			mode_s2 <= mode_s1;
			sa_s2   <= sa_s1;
			dst_s2  <= dst_s1;
		end
	end

	// stage three: flags for the output select
	always_ff @(posedge clk) begin
		if (adv3) begin
			we_s3   <= we_s2;
			full_s3 <= full_s2;
			dst_s3  <= dst_s2;
		end
	end

	assign ctl.en_s2   = adv2;
	assign ctl.en_s3   = adv3;
	assign ctl.mode_s1 = mode_s1;
	assign ctl.mode_s2 = mode_s2;
	assign ctl.color_a = color_a;
	assign ctl.sa_s1   = sa_s1;
	assign ctl.sa_s2   = sa_s2;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		cab_blend_lane u_lane (
			.clk      (clk),
			.ctl      (ctl),
			.color_c  (cab_pkg::byte_at(cfg.draw_color, i)),
			.dst_d_s1 (cab_pkg::byte_at(dst_s1, i)),
			.src_s_s1 (cab_pkg::byte_at(src_s1, i)),
			.blend_s3 (blend_s3[i*W +: W])
		);
	end

	// pick the written pixel: untouched, plain color, or blend
	always_comb begin
		priority if (!we_s3) begin
			out_pixel = dst_s3;
		end else if (full_s3) begin
			out_pixel = cfg.draw_color;
		end else begin
			out_pixel = {dst_s3[PW-1:3*W], blend_s3};
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {{(cab_pkg::OUT_DATA_W - PW - 1){1'b0}}, out_pixel, we_s3};

endmodule

[rtl/cab_cfg_regs.sv]
`timescale 1ns / 1ps

module cab_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cab_pkg::CFG_DAT_W-1:0]     cfg_data,
	output cab_pkg::cab_cfg_t                 cfg
);

	cab_pkg::cab_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cab_pkg::cab_reg_idx_t'(cfg_index))
				cab_pkg::REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_data[cab_pkg::COORD_W-1:0];
				cab_pkg::REG_CLIP_TOP:    cfg_q.clip_top    <= cfg_data[cab_pkg::COORD_W-1:0];
				cab_pkg::REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_data[cab_pkg::COORD_W-1:0];
				cab_pkg::REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_data[cab_pkg::COORD_W-1:0];
				cab_pkg::REG_DRAW_COLOR:  cfg_q.draw_color  <= cfg_data[cab_pkg::PIX_W-1:0];
				cab_pkg::REG_DRAW_MODE:   cfg_q.draw_mode   <= cab_pkg::cab_mode_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

endmodule

[rtl/cab_blend_lane.sv]
`timescale 1ns / 1ps

module cab_blend_lane (
	input  logic                           clk,
	input  cab_pkg::cab_lane_ctl_t         ctl,
	input  logic [cab_pkg::CHAN_W-1:0]     color_c,
	input  logic [cab_pkg::CHAN_W-1:0]     dst_d_s1,
	input  logic [cab_pkg::CHAN_W-1:0]     src_s_s1,
	output logic [cab_pkg::CHAN_W-1:0]     blend_s3
);

	localparam int unsigned W = cab_pkg::CHAN_W;

	logic [W-1:0]     inv_a;
	logic [2*W-1:0]   p1_s2;
	logic [2*W-1:0]   p2_s2;
	logic [3*W-1:0]   tint;
	logic [2*W:0]     fill_sum;
	logic [W:0]       img_sum;
	logic [W-1:0]     blend_d;

	// inverse alpha: scaled source alpha in image mode, color alpha in fill
	assign inv_a = (ctl.mode_s1 == cab_pkg::MODE_IMAGE) ? (cab_pkg::CHAN_MAX - ctl.sa_s1)
		: (cab_pkg::CHAN_MAX - ctl.color_a);

	// first product stage
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			p1_s2 <= (ctl.mode_s1 == cab_pkg::MODE_IMAGE) ? src_s_s1 * color_c
				: color_c * ctl.color_a;
			p2_s2 <= dst_d_s1 * inv_a;
		end
	end

	// finish: tint scale and sum, or plain fill sum
	assign tint     = p1_s2 * ctl.sa_s2;
	assign fill_sum = {1'b0, p1_s2} + {1'b0, p2_s2};
	assign img_sum  = {1'b0, tint[3*W-1:2*W]} + {1'b0, p2_s2[2*W-1:W]};
	assign blend_d  = (ctl.mode_s2 == cab_pkg::MODE_IMAGE) ? img_sum[W-1:0]
		: fill_sum[2*W-1:W];

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			blend_s3 <= blend_d;
		end
	end

endmodule

[rtl/cab_checker.sv]
`timescale 1ns / 1ps

module cab_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [cab_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);

	// a held output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// a held output beat keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	// an empty output stage means the whole pipe can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output stage empty");

	// pad bits above the pixel stay zero, config always taken
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[cab_pkg::OUT_DATA_W-1:cab_pkg::PIX_W+1] == '0))
		else $error("nonzero pad bits in output beat");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not accepted");

endmodule

bind clip_and_alpha_blend_pixel cab_checker u_cab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
